// ----- design/aff4_pkg.sv -----
package aff4_pkg;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam int PW = 2 * DW;
	localparam int CW = 2 * DW;
	localparam int DETW = 3 * DW;
	localparam int QW = DW - 1;
	localparam int SH = 2 * FB - QW;
	localparam int SUMW = PW + 2;
	localparam int FRONT_LAT = 6;
	localparam int DIV_LAT = QW + 1;
	localparam int BACK_LAT = 4;
	localparam int LAT = FRONT_LAT + DIV_LAT + BACK_LAT;

	localparam logic signed [DW-1:0] FX_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] FX_MIN = {1'b1, {(DW-1){1'b0}}};

	// cofactor k = e[a]*e[b] - e[c]*e[d]
	localparam int COF_IDX [9][4] = '{
		'{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
		'{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
		'{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
	};

	typedef logic signed [DW-1:0] fx_t;

	typedef struct packed {
		fx_t c0r0;
		fx_t c0r1;
		fx_t c0r2;
		fx_t c1r0;
		fx_t c1r1;
		fx_t c1r2;
		fx_t c2r0;
		fx_t c2r1;
		fx_t c2r2;
		fx_t trans_x;
		fx_t trans_y;
		fx_t trans_z;
	} item_in_t;

	typedef struct packed {
		fx_t inv_c0r0;
		fx_t inv_c0r1;
		fx_t inv_c0r2;
		fx_t inv_c1r0;
		fx_t inv_c1r1;
		fx_t inv_c1r2;
		fx_t inv_c2r0;
		fx_t inv_c2r1;
		fx_t inv_c2r2;
		fx_t inv_trans_x;
		fx_t inv_trans_y;
		fx_t inv_trans_z;
	} item_out_t;

	typedef struct packed {
		logic [8:0][CW-1:0] cof_mag;
		logic [8:0]         cof_neg;
		logic [DETW-1:0]    det_mag;
		logic               det_neg;
		logic               det_zero;
		logic [2:0][DW-1:0] trans;
	} front_t;

	typedef struct packed {
		logic [8:0][QW-1:0] quo;
		logic [8:0]         ovf;
		logic [8:0]         neg;
		logic               det_zero;
		logic [2:0][DW-1:0] trans;
	} quot_t;

endpackage

// ----- design/aff4_front.sv -----
module aff4_front import aff4_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  item_in_t din,
	output front_t   dout
);

	fx_t e [12];

	assign e[0]  = din.c0r0;
	assign e[1]  = din.c0r1;
	assign e[2]  = din.c0r2;
	assign e[3]  = din.c1r0;
	assign e[4]  = din.c1r1;
	assign e[5]  = din.c1r2;
	assign e[6]  = din.c2r0;
	assign e[7]  = din.c2r1;
	assign e[8]  = din.c2r2;
	assign e[9]  = din.trans_x;
	assign e[10] = din.trans_y;
	assign e[11] = din.trans_z;

	logic signed [PW-1:0] pa_s1 [9];
	logic signed [PW-1:0] pb_s1 [9];
	logic [DW-1:0]        em_s1 [3];
	logic [2:0]           eneg_s1;
	logic [DW-1:0]        tr_s1 [3];

	logic [CW-1:0]        cof_s2 [9];
	logic [8:0]           cneg_s2;
	logic [DW-1:0]        em_s2 [3];
	logic [2:0]           eneg_s2;
	logic [DW-1:0]        tr_s2 [3];

	logic [PW-1:0]        lo_s3 [3];
	logic [PW-1:0]        hi_s3 [3];
	logic [2:0]           tneg_s3;
	logic [CW-1:0]        cof_s3 [9];
	logic [8:0]           cneg_s3;
	logic [DW-1:0]        tr_s3 [3];

	logic signed [DETW:0] term_s4 [3];
	logic [CW-1:0]        cof_s4 [9];
	logic [8:0]           cneg_s4;
	logic [DW-1:0]        tr_s4 [3];

	logic signed [DETW+1:0] det_s5;
	logic [CW-1:0]        cof_s5 [9];
	logic [8:0]           cneg_s5;
	logic [DW-1:0]        tr_s5 [3];

	front_t               out_s6;

	// products of element pairs
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				pa_s1[k] <= e[COF_IDX[k][0]] * e[COF_IDX[k][1]];
				pb_s1[k] <= e[COF_IDX[k][2]] * e[COF_IDX[k][3]];
			end
			for (int j = 0; j < 3; j++) begin
				em_s1[j]   <= e[j][DW-1] ? DW'(-e[j]) : DW'(e[j]);
				eneg_s1[j] <= e[j][DW-1];
				tr_s1[j]   <= e[9+j];
			end
		end
	end

	// cofactors as sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				logic signed [PW:0] d;
				d = {pa_s1[k][PW-1], pa_s1[k]} - {pb_s1[k][PW-1], pb_s1[k]};
				cof_s2[k]  <= d[PW] ? CW'(-d) : CW'(d);
				cneg_s2[k] <= d[PW];
			end
			em_s2   <= em_s1;
			eneg_s2 <= eneg_s1;
			tr_s2   <= tr_s1;
		end
	end

	// determinant partial products, split into halves of the cofactor
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				lo_s3[j]   <= PW'(em_s2[j]) * PW'(cof_s2[3*j][DW-1:0]);
				hi_s3[j]   <= PW'(em_s2[j]) * PW'(cof_s2[3*j][CW-1:DW]);
				tneg_s3[j] <= eneg_s2[j] ^ cneg_s2[3*j];
			end
			cof_s3  <= cof_s2;
			cneg_s3 <= cneg_s2;
			tr_s3   <= tr_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				logic [DETW-1:0] m;
				m = {hi_s3[j], {DW{1'b0}}} + DETW'(lo_s3[j]);
				term_s4[j] <= tneg_s3[j] ? -$signed({1'b0, m}) : $signed({1'b0, m});
			end
			cof_s4  <= cof_s3;
			cneg_s4 <= cneg_s3;
			tr_s4   <= tr_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= (DETW+2)'(term_s4[0]) + (DETW+2)'(term_s4[1]) + (DETW+2)'(term_s4[2]);
			cof_s5  <= cof_s4;
			cneg_s5 <= cneg_s4;
			tr_s5   <= tr_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				out_s6.cof_mag[k] <= cof_s5[k];
			end
			for (int j = 0; j < 3; j++) begin
				out_s6.trans[j] <= tr_s5[j];
			end
			out_s6.cof_neg  <= cneg_s5;
			out_s6.det_mag  <= det_s5[DETW+1] ? DETW'(-det_s5) : DETW'(det_s5);
			out_s6.det_neg  <= det_s5[DETW+1];
			out_s6.det_zero <= (det_s5 == '0);
		end
	end

	assign dout = out_s6;

endmodule

// ----- design/aff4_div.sv -----
module aff4_div import aff4_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  front_t din,
	output quot_t  dout
);

	logic [DETW-1:0]    den_s  [DIV_LAT];
	logic [DETW-1:0]    rem_s  [DIV_LAT][9];
	logic [QW-1:0]      quo_s  [DIV_LAT][9];
	logic [8:0]         ovf_s  [DIV_LAT];
	logic [8:0]         neg_s  [DIV_LAT];
	logic               zero_s [DIV_LAT];
	logic [2:0][DW-1:0] tr_s   [DIV_LAT];

	// first stage: overflow check and partial remainder
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				logic [DETW:0] init;
				logic          big;
				init = (DETW+1)'({din.cof_mag[k], {SH{1'b0}}});
				big  = (init >= {1'b0, din.det_mag});
				rem_s[0][k] <= big ? '0 : DETW'(init);
				quo_s[0][k] <= '0;
				ovf_s[0][k] <= big;
				neg_s[0][k] <= din.cof_neg[k] ^ din.det_neg;
			end
			den_s[0]  <= din.det_mag;
			zero_s[0] <= din.det_zero;
			tr_s[0]   <= din.trans;
		end
	end

	// one quotient bit per stage
	for (genvar i = 1; i < DIV_LAT; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 9; k++) begin
					logic [DETW:0] t;
					logic          ge;
					t  = {rem_s[i-1][k], 1'b0};
					ge = (t >= {1'b0, den_s[i-1]});
					rem_s[i][k] <= ge ? DETW'(t - {1'b0, den_s[i-1]}) : DETW'(t);
					quo_s[i][k] <= {quo_s[i-1][k][QW-2:0], ge};
				end
				den_s[i]  <= den_s[i-1];
				ovf_s[i]  <= ovf_s[i-1];
				neg_s[i]  <= neg_s[i-1];
				zero_s[i] <= zero_s[i-1];
				tr_s[i]   <= tr_s[i-1];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			dout.quo[k] = quo_s[DIV_LAT-1][k];
		end
		dout.ovf      = ovf_s[DIV_LAT-1];
		dout.neg      = neg_s[DIV_LAT-1];
		dout.det_zero = zero_s[DIV_LAT-1];
		dout.trans    = tr_s[DIV_LAT-1];
	end

endmodule

// ----- design/aff4_back.sv -----
module aff4_back import aff4_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  quot_t     din,
	output item_out_t dout
);

	fx_t                  inv_s1  [9];
	fx_t                  tr_s1   [3];
	logic signed [PW-1:0] prod_s2 [9];
	fx_t                  inv_s2  [9];
	logic signed [SUMW-1:0] sum_s3 [3];
	fx_t                  inv_s3  [9];
	fx_t                  res_s4  [12];

	// signed, saturated inverse elements; zero for a singular matrix
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				fx_t q;
				q = fx_t'({1'b0, din.quo[k]});
				if (din.det_zero) begin
					inv_s1[k] <= '0;
				end else if (din.ovf[k]) begin
					inv_s1[k] <= din.neg[k] ? FX_MIN : FX_MAX;
				end else begin
					inv_s1[k] <= din.neg[k] ? -q : q;
				end
			end
			for (int j = 0; j < 3; j++) begin
				tr_s1[j] <= din.trans[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s2[3*r+k] <= inv_s1[3*k+r] * tr_s1[k];
				end
			end
			inv_s2 <= inv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				sum_s3[r] <= SUMW'(prod_s2[3*r]) + SUMW'(prod_s2[3*r+1])
					+ SUMW'(prod_s2[3*r+2]);
			end
			inv_s3 <= inv_s2;
		end
	end

	// negate, drop fraction toward zero, saturate
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				logic [SUMW-1:0] mag;
				logic [SUMW-1:0] m;
				mag = sum_s3[r][SUMW-1] ? SUMW'(-sum_s3[r]) : SUMW'(sum_s3[r]);
				m   = mag >> FB;
				if (sum_s3[r][SUMW-1]) begin
					res_s4[9+r] <= (m > SUMW'(FX_MAX)) ? FX_MAX : fx_t'(m[DW-1:0]);
				end else begin
					res_s4[9+r] <= (m >= SUMW'({1'b1, {(DW-1){1'b0}}})) ? FX_MIN
						: -fx_t'(m[DW-1:0]);
				end
			end
			for (int k = 0; k < 9; k++) begin
				res_s4[k] <= inv_s3[k];
			end
		end
	end

	assign dout.inv_c0r0    = res_s4[0];
	assign dout.inv_c0r1    = res_s4[1];
	assign dout.inv_c0r2    = res_s4[2];
	assign dout.inv_c1r0    = res_s4[3];
	assign dout.inv_c1r1    = res_s4[4];
	assign dout.inv_c1r2    = res_s4[5];
	assign dout.inv_c2r0    = res_s4[6];
	assign dout.inv_c2r1    = res_s4[7];
	assign dout.inv_c2r2    = res_s4[8];
	assign dout.inv_trans_x = res_s4[9];
	assign dout.inv_trans_y = res_s4[10];
	assign dout.inv_trans_z = res_s4[11];

endmodule

// ----- design/affine_matrix4_inverse_core.sv -----
// channel   direction  handshake               payload
// in        input      in_valid / in_ready     in_data   (item_in_t)
// out       output     out_valid / out_ready   out_data  (item_out_t)
//
// one transfer per cycle in each direction unless the output stalls; the pipeline has
// 6 cofactor/determinant stages, 32 divider stages and 4 output stages
// the divider retires one quotient bit per stage after its first, in each of nine lanes
// arst_n clears the valid bits only; the datapath has no reset
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
module affine_matrix4_inverse_core import aff4_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  item_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output item_out_t out_data
);

	logic [LAT-1:0] stage_vld_q;
	logic           en;
	front_t         front;
	quot_t          quot;

	assign en        = ~stage_vld_q[LAT-1] | out_ready;
	assign in_ready  = en;
	assign out_valid = stage_vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (en) begin
			stage_vld_q <= {stage_vld_q[LAT-2:0], in_valid};
		end
	end

	aff4_front u_front (
		.clk  (clk),
		.en   (en),
		.din  (in_data),
		.dout (front)
	);

	aff4_div u_div (
		.clk  (clk),
		.en   (en),
		.din  (front),
		.dout (quot)
	);

	aff4_back u_back (
		.clk  (clk),
		.en   (en),
		.din  (quot),
		.dout (out_data)
	);

`ifndef ASSERT_OFF
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(stage_vld_q))
		else $error("valid bits moved during stall");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> stage_vld_q[0])
		else $error("accepted transfer lost at entry");

	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid && in_ready |=> !stage_vld_q[0])
		else $error("transfer invented at entry");
`endif

endmodule

// ----- sim/inverse_checker.sv -----
module inverse_checker import aff4_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  item_in_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  item_out_t out_data,
	output int        errors,
	output int        pending
);

	typedef logic signed [255:0] big_t;

	item_out_t expected_inverses[$];

	const string field_name [12] = '{"inv_c0r0", "inv_c0r1", "inv_c0r2", "inv_c1r0",
		"inv_c1r1", "inv_c1r2", "inv_c2r0", "inv_c2r1", "inv_c2r2",
		"inv_trans_x", "inv_trans_y", "inv_trans_z"};

	function automatic fx_t clamp_fx(big_t v);
		big_t hi;
		big_t lo;
		hi = FX_MAX;
		lo = FX_MIN;
		if (v > hi) begin
			return FX_MAX;
		end
		if (v < lo) begin
			return FX_MIN;
		end
		return fx_t'(v[DW-1:0]);
	endfunction

	function automatic item_out_t invert_affine(item_in_t m);
		logic [11:0][DW-1:0] raw;
		logic [11:0][DW-1:0] res;
		big_t e [12];
		big_t cof [9];
		big_t det;
		big_t acc;
		raw = m;
		for (int k = 0; k < 12; k++) begin
			e[k] = $signed(raw[11-k]);
		end
		for (int k = 0; k < 9; k++) begin
			cof[k] = e[COF_IDX[k][0]] * e[COF_IDX[k][1]] - e[COF_IDX[k][2]] * e[COF_IDX[k][3]];
		end
		det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
		res = '0;
		if (det != 0) begin
			for (int k = 0; k < 9; k++) begin
				res[11-k] = clamp_fx((cof[k] <<< (2 * FB)) / det);
			end
			for (int r = 0; r < 3; r++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) begin
					acc = acc + big_t'($signed(res[11-(k*3+r)])) * e[9+k];
				end
				acc = -acc;
				res[2-r] = clamp_fx(acc / (big_t'(1) <<< FB));
			end
		end
		return item_out_t'(res);
	endfunction

	assign pending = expected_inverses.size();

	always @(posedge clk or negedge arst_n) begin
		item_out_t want;
		logic [11:0][DW-1:0] w;
		logic [11:0][DW-1:0] g;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_inverses.push_back(invert_affine(in_data));
			end
			if (out_valid && out_ready) begin
				if (expected_inverses.size() == 0) begin
					$error("output transfer with nothing expected");
					errors <= errors + 1;
				end else begin
					want = expected_inverses.pop_front();
					w = want;
					g = out_data;
					for (int k = 0; k < 12; k++) begin
						if (w[11-k] !== g[11-k]) begin
							$error("%s expected %0d got %0d", field_name[k],
								$signed(w[11-k]), $signed(g[11-k]));
						end
					end
					if (want !== out_data) begin
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ----- sim/testbench.sv -----
module testbench;
	import aff4_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	item_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	item_out_t out_data;
	int        errors;
	int        pending;
	int        idle_pct;
	int        stall_pct;

	localparam fx_t ONE = fx_t'(1 <<< FB);

	affine_matrix4_inverse_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	inverse_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_matrix(input item_in_t m);
		logic rdy;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= m;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	function automatic fx_t near_fx(int span);
		return fx_t'($signed($urandom_range(2 * span)) - span);
	endfunction

	function automatic item_in_t random_matrix();
		item_in_t m;
		logic [11:0][DW-1:0] raw;
		int pick;
		pick = $urandom_range(99);
		if (pick < 15) begin
			for (int k = 0; k < 12; k++) begin
				raw[k] = $urandom;
			end
			m = raw;
		end else if (pick < 25) begin
			// singular: two equal columns
			m = random_matrix_small();
			m.c2r0 = m.c0r0;
			m.c2r1 = m.c0r1;
			m.c2r2 = m.c0r2;
		end else if (pick < 35) begin
			// near-singular, quotients tend to saturate
			for (int k = 0; k < 12; k++) begin
				raw[k] = near_fx(40);
			end
			m = raw;
		end else begin
			m = random_matrix_small();
		end
		return m;
	endfunction

	function automatic item_in_t random_matrix_small();
		item_in_t m;
		logic [11:0][DW-1:0] raw;
		for (int k = 0; k < 9; k++) begin
			raw[k+3] = near_fx(1 << (FB + 2));
		end
		for (int k = 0; k < 3; k++) begin
			raw[k] = near_fx(1 << (FB + 8));
		end
		m = raw;
		return m;
	endfunction

	initial begin
		item_in_t m;
		logic [11:0][DW-1:0] raw;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, with and without translation
		m = '0;
		m.c0r0 = ONE; m.c1r1 = ONE; m.c2r2 = ONE;
		send_matrix(m);
		m.trans_x = fx_t'(3 * ONE); m.trans_y = -ONE; m.trans_z = FX_MAX;
		send_matrix(m);
		m.trans_x = FX_MIN; m.trans_y = FX_MIN; m.trans_z = FX_MIN;
		send_matrix(m);
		// all zero, singular
		send_matrix('0);
		// scale by two, by a half and by minus one
		m = '0;
		m.c0r0 = fx_t'(2 * ONE); m.c1r1 = fx_t'(ONE / 2); m.c2r2 = -ONE;
		m.trans_x = ONE; m.trans_y = ONE; m.trans_z = ONE;
		send_matrix(m);
		// tiny diagonal, inverse saturates high and, with a negative entry, low
		m = '0;
		m.c0r0 = 1; m.c1r1 = 1; m.c2r2 = 1; m.trans_x = FX_MAX;
		send_matrix(m);
		m.c0r0 = -1;
		send_matrix(m);
		// extreme elements
		for (int k = 0; k < 12; k++) begin
			raw[k] = FX_MAX;
		end
		send_matrix(item_in_t'(raw));
		for (int k = 0; k < 12; k++) begin
			raw[k] = FX_MIN;
		end
		send_matrix(item_in_t'(raw));
		m = '0;
		m.c0r0 = FX_MIN; m.c1r1 = FX_MIN; m.c2r2 = FX_MIN;
		m.trans_x = FX_MAX; m.trans_y = FX_MIN; m.trans_z = -1;
		send_matrix(m);
		m = '0;
		m.c0r0 = FX_MAX; m.c1r1 = FX_MAX; m.c2r2 = FX_MAX;
		m.c1r0 = FX_MIN; m.c2r1 = FX_MIN; m.c0r2 = FX_MIN;
		m.trans_x = FX_MAX; m.trans_y = FX_MAX; m.trans_z = FX_MAX;
		send_matrix(m);
		// permutation
		m = '0;
		m.c0r1 = ONE; m.c1r2 = ONE; m.c2r0 = ONE;
		m.trans_x = 12345; m.trans_y = -54321; m.trans_z = 7;
		send_matrix(m);
		// rank two, one zero row
		m = '0;
		m.c0r0 = ONE; m.c1r1 = ONE; m.trans_z = ONE;
		send_matrix(m);
		// alternating bit patterns
		for (int k = 0; k < 12; k++) begin
			raw[k] = (k % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA;
		end
		send_matrix(item_in_t'(raw));
		for (int k = 0; k < 12; k++) begin
			raw[k] = (k % 2) ? 32'hAAAA_AAAA : 32'h5555_5555;
		end
		send_matrix(item_in_t'(raw));

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 37 : 46) : 0;
			stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 37 : 46) : 0;
			for (int i = 0; i < 200; i++) begin
				send_matrix(random_matrix());
			end
		end
		in_valid <= 1'b0;
		stall_pct = 0;

		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (LAT + 10) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
